// ----- design/zsdc_pkg.sv -----
// Shared types, constants and helpers for the zigzag sweep drive controller.
package zsdc_pkg;

  localparam int AngW = 15;
  typedef logic signed [AngW-1:0] ang_t;

  localparam ang_t ANG_SIDE_HI  = ang_t'(-1360);
  localparam ang_t ANG_SIDE_LO  = ang_t'(-1520);
  localparam ang_t ANG_RET_HOLD = ang_t'(2720);
  localparam ang_t ANG_QUARTER  = ang_t'(-1440);
  localparam ang_t ANG_HALF     = ang_t'(-2880);

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_LEFT  = 2'd2,
    DRV_RIGHT = 2'd3
  } drive_t;

  typedef enum logic [10:0] {
    PH_IDLE       = 11'b000_0000_0001,
    PH_OUT_HOLD   = 11'b000_0000_0010,
    PH_OUT_TURN_Q = 11'b000_0000_0100,
    PH_OUT_SIDE   = 11'b000_0000_1000,
    PH_OUT_DWELL  = 11'b000_0001_0000,
    PH_OUT_TURN_H = 11'b000_0010_0000,
    PH_RET_HOLD   = 11'b000_0100_0000,
    PH_RET_TURN_Q = 11'b000_1000_0000,
    PH_RET_SIDE   = 11'b001_0000_0000,
    PH_RET_DWELL  = 11'b010_0000_0000,
    PH_RET_TURN_Z = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CFG_HEADING_BAND = 2'd0,
    CFG_NEAR_OUT     = 2'd1,
    CFG_NEAR_RET     = 2'd2,
    CFG_DWELL_TICKS  = 2'd3
  } cfg_idx_t;

  localparam logic [11:0] RST_HEADING_BAND = 12'd160;
  localparam logic [15:0] RST_NEAR_OUT     = 16'd320;
  localparam logic [15:0] RST_NEAR_RET     = 16'd160;
  localparam logic [15:0] RST_DWELL_TICKS  = 16'd500;

  typedef struct packed {
    logic [11:0] heading_band;
    logic [15:0] near_out;
    logic [15:0] near_ret;
    logic [15:0] dwell_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        leg;
    logic [15:0] dwell;
    drive_t      drive;
  } state_t;

  typedef struct packed {
    logic               action;
    logic               run;
    logic signed [12:0] heading;
    logic [15:0]        distance;
  } item_t;

  function automatic logic [3:0] phase_num(phase_t ph);
    logic [3:0] n;
    unique case (ph)
      PH_IDLE:       n = 4'd0;
      PH_OUT_HOLD:   n = 4'd1;
      PH_OUT_TURN_Q: n = 4'd2;
      PH_OUT_SIDE:   n = 4'd3;
      PH_OUT_DWELL:  n = 4'd4;
      PH_OUT_TURN_H: n = 4'd5;
      PH_RET_HOLD:   n = 4'd6;
      PH_RET_TURN_Q: n = 4'd7;
      PH_RET_SIDE:   n = 4'd8;
      PH_RET_DWELL:  n = 4'd9;
      PH_RET_TURN_Z: n = 4'd10;
      default:       n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- design/zsdc_cfg.sv -----
// Configuration register bank for the sweep controller.
module zsdc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output zsdc_pkg::cfg_t      cfg
);

  zsdc_pkg::cfg_t cfg_r;
  zsdc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (zsdc_pkg::cfg_idx_t'(cfg_index))
        zsdc_pkg::CFG_HEADING_BAND: cfg_nxt.heading_band = cfg_data[11:0];
        zsdc_pkg::CFG_NEAR_OUT:     cfg_nxt.near_out     = cfg_data;
        zsdc_pkg::CFG_NEAR_RET:     cfg_nxt.near_ret     = cfg_data;
        zsdc_pkg::CFG_DWELL_TICKS:  cfg_nxt.dwell_ticks  = cfg_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heading_band <= zsdc_pkg::RST_HEADING_BAND;
      cfg_r.near_out     <= zsdc_pkg::RST_NEAR_OUT;
      cfg_r.near_ret     <= zsdc_pkg::RST_NEAR_RET;
      cfg_r.dwell_ticks  <= zsdc_pkg::RST_DWELL_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/zsdc_step.sv -----
// Next-state logic of the sweep: one update or tick applied to the state.
module zsdc_step (
  input  zsdc_pkg::cfg_t   cfg,
  input  zsdc_pkg::state_t cur,
  input  zsdc_pkg::item_t  item,
  output zsdc_pkg::state_t nxt
);

  zsdc_pkg::ang_t   h;
  zsdc_pkg::ang_t   band;
  zsdc_pkg::ang_t   nband;
  zsdc_pkg::drive_t side_drive;
  logic             in_dwell;
  logic [15:0]      cnt_dec;
  logic             no_dwell;

  always_comb begin
    h        = zsdc_pkg::ang_t'(item.heading);
    band     = zsdc_pkg::ang_t'(cfg.heading_band);
    nband    = -band;
    in_dwell = (cur.phase == zsdc_pkg::PH_OUT_DWELL) ||
               (cur.phase == zsdc_pkg::PH_RET_DWELL);
    no_dwell = (cfg.dwell_ticks == 16'd0);
    cnt_dec  = (cur.dwell != 16'd0) ? cur.dwell - 16'd1 : cur.dwell;

    if (h > zsdc_pkg::ANG_SIDE_HI) begin
      side_drive = zsdc_pkg::DRV_RIGHT;
    end else if (h < zsdc_pkg::ANG_SIDE_LO) begin
      side_drive = zsdc_pkg::DRV_LEFT;
    end else begin
      side_drive = zsdc_pkg::DRV_FWD;
    end

    nxt = cur;
    if (item.action) begin
      if (in_dwell) begin
        nxt.dwell = cnt_dec;
        if (cnt_dec == 16'd0) begin
          nxt.phase = (cur.phase == zsdc_pkg::PH_OUT_DWELL) ? zsdc_pkg::PH_OUT_TURN_H
                                                            : zsdc_pkg::PH_RET_TURN_Z;
        end
      end
    end else if (!in_dwell) begin
      if (!item.run) begin
        nxt.phase = zsdc_pkg::PH_IDLE;
        nxt.drive = zsdc_pkg::DRV_STOP;
      end else begin
        unique case (cur.phase)
          zsdc_pkg::PH_IDLE: begin
            nxt.phase = cur.leg ? zsdc_pkg::PH_RET_HOLD : zsdc_pkg::PH_OUT_HOLD;
          end
          zsdc_pkg::PH_OUT_HOLD: begin
            nxt.drive = zsdc_pkg::DRV_FWD;
            if (h > band) nxt.drive = zsdc_pkg::DRV_RIGHT;
            if (h < nband) nxt.drive = zsdc_pkg::DRV_LEFT;
            if (item.distance < cfg.near_out) nxt.phase = zsdc_pkg::PH_OUT_TURN_Q;
          end
          zsdc_pkg::PH_OUT_TURN_Q: begin
            nxt.drive = zsdc_pkg::DRV_RIGHT;
            if (h < zsdc_pkg::ANG_QUARTER + band) nxt.phase = zsdc_pkg::PH_OUT_SIDE;
          end
          zsdc_pkg::PH_OUT_SIDE: begin
            nxt.drive = side_drive;
            nxt.dwell = cfg.dwell_ticks;
            nxt.phase = no_dwell ? zsdc_pkg::PH_OUT_TURN_H : zsdc_pkg::PH_OUT_DWELL;
          end
          zsdc_pkg::PH_OUT_TURN_H: begin
            nxt.drive = zsdc_pkg::DRV_RIGHT;
            if (h < zsdc_pkg::ANG_HALF + band) begin
              nxt.leg   = 1'b1;
              nxt.phase = zsdc_pkg::PH_IDLE;
            end
          end
          zsdc_pkg::PH_RET_HOLD: begin
            nxt.drive = zsdc_pkg::DRV_FWD;
            if (h < -zsdc_pkg::ANG_RET_HOLD) nxt.drive = zsdc_pkg::DRV_RIGHT;
            if (h > zsdc_pkg::ANG_RET_HOLD) nxt.drive = zsdc_pkg::DRV_LEFT;
            if (item.distance < cfg.near_ret) nxt.phase = zsdc_pkg::PH_RET_TURN_Q;
          end
          zsdc_pkg::PH_RET_TURN_Q: begin
            nxt.drive = zsdc_pkg::DRV_LEFT;
            if (h > zsdc_pkg::ANG_QUARTER) nxt.phase = zsdc_pkg::PH_RET_SIDE;
          end
          zsdc_pkg::PH_RET_SIDE: begin
            nxt.drive = side_drive;
            nxt.dwell = cfg.dwell_ticks;
            nxt.phase = no_dwell ? zsdc_pkg::PH_RET_TURN_Z : zsdc_pkg::PH_RET_DWELL;
          end
          zsdc_pkg::PH_RET_TURN_Z: begin
            nxt.drive = zsdc_pkg::DRV_LEFT;
            if (h > nband) begin
              nxt.leg   = 1'b0;
              nxt.phase = zsdc_pkg::PH_IDLE;
            end
          end
          default: begin
            nxt.phase = zsdc_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ----- design/zigzag_sweep_drive_controller.sv -----
// Top level of the zigzag sweep drive controller: request and result registers.
// Flow: an accepted request is captured in the request register, then its result in the result register.
// Throughput: one request per cycle while out_stall is low; the result register frees the input side.
// The state update sits between the request register and the result register.
// Reset: synchronous, active low; clears phase to idle, leg, dwell count and drive,
// and loads the configuration registers with their defaults.
module zigzag_sweep_drive_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic               in_run_command,
  input  logic signed [12:0] in_heading,
  input  logic [15:0]        in_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_drive,
  output logic [3:0]         out_phase,
  output logic               out_return_leg
);

  zsdc_pkg::cfg_t   cfg;
  zsdc_pkg::state_t state_r;
  zsdc_pkg::state_t state_nxt;
  zsdc_pkg::item_t  s1_item_r;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [1:0]       out_drive_r;
  logic [3:0]       out_phase_r;
  logic             out_leg_r;
  logic             in_fire;
  logic             s1_fire;

  zsdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  zsdc_step u_step (
    .cfg  (cfg),
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt)
  );

  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.phase <= zsdc_pkg::PH_IDLE;
      state_r.leg   <= 1'b0;
      state_r.dwell <= 16'd0;
      state_r.drive <= zsdc_pkg::DRV_STOP;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action   <= in_action;
      s1_item_r.run      <= in_run_command;
      s1_item_r.heading  <= in_heading;
      s1_item_r.distance <= in_distance;
    end
    if (s1_fire) begin
      out_drive_r <= state_nxt.drive;
      out_phase_r <= zsdc_pkg::phase_num(state_nxt.phase);
      out_leg_r   <= state_nxt.leg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = out_drive_r;
  assign out_phase      = out_phase_r;
  assign out_return_leg = out_leg_r;

  a_dwell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r.phase == zsdc_pkg::PH_OUT_DWELL) || (state_r.phase == zsdc_pkg::PH_RET_DWELL))
    |-> (state_r.dwell != 16'd0))
    else $error("dwell phase held with zero count");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !s1_fire) |=> $stable(state_r))
    else $error("state moved without a request");

  a_leg_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (state_nxt.leg != state_r.leg)) |=> (state_r.phase == zsdc_pkg::PH_IDLE))
    else $error("leg flag changed outside a turn end");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_valid_r && (out_drive_r == state_r.drive) &&
                 (out_return_leg == state_r.leg)))
    else $error("result does not match state");

endmodule

// ----- sim/zigzag_sweep_drive_controller_tb.sv -----
// Testbench for the zigzag sweep drive controller: directed table, shaped random sweeps, predictor.
`timescale 1ns / 1ps

module zigzag_sweep_drive_controller_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int FLOOD_CYCLES = 400;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;
  localparam logic RUN_STOP   = 1'b0;
  localparam logic RUN_GO     = 1'b1;

  localparam logic [3:0] P_IDLE       = 4'd0;
  localparam logic [3:0] P_OUT_HOLD   = 4'd1;
  localparam logic [3:0] P_OUT_TURN_Q = 4'd2;
  localparam logic [3:0] P_OUT_SIDE   = 4'd3;
  localparam logic [3:0] P_OUT_DWELL  = 4'd4;
  localparam logic [3:0] P_OUT_TURN_H = 4'd5;
  localparam logic [3:0] P_RET_HOLD   = 4'd6;
  localparam logic [3:0] P_RET_TURN_Q = 4'd7;
  localparam logic [3:0] P_RET_SIDE   = 4'd8;
  localparam logic [3:0] P_RET_DWELL  = 4'd9;
  localparam logic [3:0] P_RET_TURN_Z = 4'd10;

  typedef struct packed {
    zsdc_pkg::drive_t drive;
    logic [3:0]       phase;
    logic             leg;
  } sweep_out_t;

  typedef struct {
    bit                 is_cfg;
    zsdc_pkg::cfg_idx_t idx;
    logic [15:0]        data;
    zsdc_pkg::item_t    req;
    bit                 typed;
    sweep_out_t         want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic               in_run_command = 1'b0;
  logic signed [12:0] in_heading = '0;
  logic [15:0]        in_distance = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_drive;
  logic [3:0]         out_phase;
  logic               out_return_leg;

  logic [11:0]      cf_band;
  logic [15:0]      cf_near_out;
  logic [15:0]      cf_near_ret;
  logic [15:0]      cf_dwell;
  logic [3:0]       pr_phase;
  logic             pr_leg;
  logic [15:0]      pr_dwell;
  zsdc_pkg::drive_t pr_drive;

  sweep_out_t pending_out[$];
  plan_row_t  plan[$];
  int         mismatches = 0;
  int         cycle_cnt = 0;
  bit         flood_req = 1'b0;
  bit         flood_done = 1'b0;

  zigzag_sweep_drive_controller dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_run_command (in_run_command),
    .in_heading     (in_heading),
    .in_distance    (in_distance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive      (out_drive),
    .out_phase      (out_phase),
    .out_return_leg (out_return_leg)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("zigzag_sweep_drive_controller: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    sweep_out_t exp_out;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        $error("result with no request pending: drive %0d phase %0d leg %0d",
               out_drive, out_phase, out_return_leg);
        mismatches++;
      end else begin
        exp_out = pending_out.pop_front();
        if (out_drive !== exp_out.drive) begin
          $error("drive expected %0d actual %0d", exp_out.drive, out_drive);
          mismatches++;
        end
        if (out_phase !== exp_out.phase) begin
          $error("phase expected %0d actual %0d", exp_out.phase, out_phase);
          mismatches++;
        end
        if (out_return_leg !== exp_out.leg) begin
          $error("return_leg expected %0d actual %0d", exp_out.leg, out_return_leg);
          mismatches++;
        end
      end
    end
  end

  task automatic advance_sweep(input zsdc_pkg::item_t r, input bit typed,
                               input sweep_out_t want);
    int h;
    int band;
    sweep_out_t res;
    h = int'(r.heading);
    band = int'(cf_band);
    if (r.action == ACT_TICK) begin
      if (pr_phase == P_OUT_DWELL || pr_phase == P_RET_DWELL) begin
        if (pr_dwell != 0) pr_dwell--;
        if (pr_dwell == 0) pr_phase++;
      end
    end else if (pr_phase != P_OUT_DWELL && pr_phase != P_RET_DWELL) begin
      if (r.run == RUN_STOP) begin
        pr_phase = P_IDLE;
        pr_drive = zsdc_pkg::DRV_STOP;
      end else begin
        unique case (pr_phase)
          P_IDLE: pr_phase = pr_leg ? P_RET_HOLD : P_OUT_HOLD;
          P_OUT_HOLD: begin
            pr_drive = zsdc_pkg::DRV_FWD;
            if (h > band) pr_drive = zsdc_pkg::DRV_RIGHT;
            if (h < -band) pr_drive = zsdc_pkg::DRV_LEFT;
            if (r.distance < cf_near_out) pr_phase = P_OUT_TURN_Q;
          end
          P_OUT_TURN_Q: begin
            pr_drive = zsdc_pkg::DRV_RIGHT;
            if (h < int'(zsdc_pkg::ANG_QUARTER) + band) pr_phase = P_OUT_SIDE;
          end
          P_OUT_SIDE, P_RET_SIDE: begin
            pr_drive = zsdc_pkg::DRV_FWD;
            if (h > int'(zsdc_pkg::ANG_SIDE_HI)) pr_drive = zsdc_pkg::DRV_RIGHT;
            if (h < int'(zsdc_pkg::ANG_SIDE_LO)) pr_drive = zsdc_pkg::DRV_LEFT;
            pr_dwell = cf_dwell;
            pr_phase = pr_phase + ((cf_dwell == 0) ? 4'd2 : 4'd1);
          end
          P_OUT_TURN_H: begin
            pr_drive = zsdc_pkg::DRV_RIGHT;
            if (h < int'(zsdc_pkg::ANG_HALF) + band) begin
              pr_leg = 1'b1;
              pr_phase = P_IDLE;
            end
          end
          P_RET_HOLD: begin
            pr_drive = zsdc_pkg::DRV_FWD;
            if (h < -int'(zsdc_pkg::ANG_RET_HOLD)) pr_drive = zsdc_pkg::DRV_RIGHT;
            if (h > int'(zsdc_pkg::ANG_RET_HOLD)) pr_drive = zsdc_pkg::DRV_LEFT;
            if (r.distance < cf_near_ret) pr_phase = P_RET_TURN_Q;
          end
          P_RET_TURN_Q: begin
            pr_drive = zsdc_pkg::DRV_LEFT;
            if (h > int'(zsdc_pkg::ANG_QUARTER)) pr_phase = P_RET_SIDE;
          end
          P_RET_TURN_Z: begin
            pr_drive = zsdc_pkg::DRV_LEFT;
            if (h > -band) begin
              pr_leg = 1'b0;
              pr_phase = P_IDLE;
            end
          end
          default: pr_phase = P_IDLE;
        endcase
      end
    end
    res.drive = pr_drive;
    res.phase = pr_phase;
    res.leg = pr_leg;
    pending_out.push_back(typed ? want : res);
  endtask

  function automatic zsdc_pkg::item_t shape_request();
    zsdc_pkg::item_t r;
    int c;
    int w;
    int h;
    bit in_dwell;
    r.action = ACT_UPDATE;
    r.run = RUN_GO;
    r.heading = 13'($urandom);
    r.distance = 16'($urandom);
    if ($urandom_range(99) < 12) begin
      r.action = 1'($urandom);
      r.run = 1'($urandom);
      return r;
    end
    if ($urandom_range(99) < 3) r.run = RUN_STOP;
    in_dwell = (pr_phase == P_OUT_DWELL || pr_phase == P_RET_DWELL);
    if (in_dwell) r.action = ($urandom_range(9) != 0) ? ACT_TICK : ACT_UPDATE;
    else r.action = ($urandom_range(9) == 0) ? ACT_TICK : ACT_UPDATE;
    w = 400;
    unique case (pr_phase)
      P_OUT_HOLD: begin
        c = 0;
        w = 2 * int'(cf_band) + 16;
        if ($urandom_range(3) == 0) r.distance = 16'($urandom_range(cf_near_out));
      end
      P_OUT_TURN_Q, P_OUT_SIDE, P_RET_TURN_Q, P_RET_SIDE: begin
        c = int'(zsdc_pkg::ANG_QUARTER);
        w = 400 + int'(cf_band);
      end
      P_OUT_TURN_H: c = int'(zsdc_pkg::ANG_HALF) + int'(cf_band);
      P_RET_HOLD: begin
        c = $urandom_range(1) ? int'(zsdc_pkg::ANG_RET_HOLD) : -int'(zsdc_pkg::ANG_RET_HOLD);
        if ($urandom_range(3) == 0) r.distance = 16'($urandom_range(cf_near_ret));
      end
      P_RET_TURN_Z: c = -int'(cf_band);
      default: begin
        c = 0;
        w = 4096;
      end
    endcase
    h = c + int'($urandom_range(2 * w)) - w;
    if (h > 4095) h = 4095;
    if (h < -4096) h = -4096;
    r.heading = 13'(h);
    return r;
  endfunction

  task automatic send_request(input zsdc_pkg::item_t r, input bit typed,
                              input sweep_out_t want);
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= r.action;
    in_run_command <= r.run;
    in_heading <= r.heading;
    in_distance <= r.distance;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sweep(r, typed, want);
  endtask

  task automatic idle_gap(input bit calm);
    int n;
    int pick;
    pick = $urandom_range(99);
    if (calm || pick < 50) n = 0;
    else if (pick < 85) n = $urandom_range(3, 1);
    else if (pick < 97) n = $urandom_range(10, 4);
    else n = $urandom_range(50, 20);
    if (n > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input zsdc_pkg::cfg_idx_t idx, input logic [15:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk) cfg_we <= 1'b0;
    unique case (idx)
      zsdc_pkg::CFG_HEADING_BAND: cf_band = v[11:0];
      zsdc_pkg::CFG_NEAR_OUT:     cf_near_out = v;
      zsdc_pkg::CFG_NEAR_RET:     cf_near_ret = v;
      zsdc_pkg::CFG_DWELL_TICKS:  cf_dwell = v;
      default: ;
    endcase
  endtask

  function automatic void plan_item(bit act, bit run, int h, int d, bit typed = 0,
                                    zsdc_pkg::drive_t dv = zsdc_pkg::DRV_STOP,
                                    int ph = 0, bit lg = 0);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = zsdc_pkg::CFG_HEADING_BAND;
    row.data = '0;
    row.req.action = act;
    row.req.run = run;
    row.req.heading = 13'(h);
    row.req.distance = 16'(d);
    row.typed = typed;
    row.want.drive = dv;
    row.want.phase = 4'(ph);
    row.want.leg = lg;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(zsdc_pkg::cfg_idx_t idx, logic [15:0] v);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = v;
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  initial begin
    while (1) begin
      int n;
      int s;
      int pick;
      if (flood_req && !flood_done) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (FLOOD_CYCLES) @(negedge clk);
        flood_done = 1'b1;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(6);
      @(negedge clk) out_stall <= 1'b0;
      repeat (n) @(negedge clk);
      pick = $urandom_range(99);
      if (pick < 70) s = $urandom_range(3);
      else if (pick < 95) s = $urandom_range(10, 4);
      else s = $urandom_range(60, 20);
      if (s > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (s - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [15:0] set_band[5];
    logic [15:0] set_near_out[5];
    logic [15:0] set_near_ret[5];
    logic [15:0] set_dwell[5];
    int          set_items[5];

    cf_band = zsdc_pkg::RST_HEADING_BAND;
    cf_near_out = zsdc_pkg::RST_NEAR_OUT;
    cf_near_ret = zsdc_pkg::RST_NEAR_RET;
    cf_dwell = zsdc_pkg::RST_DWELL_TICKS;
    pr_phase = P_IDLE;
    pr_leg = 1'b0;
    pr_dwell = '0;
    pr_drive = zsdc_pkg::DRV_STOP;

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    plan_item(ACT_UPDATE, RUN_STOP, 0, 0, 1, zsdc_pkg::DRV_STOP, P_IDLE, 0);
    plan_item(ACT_TICK, RUN_GO, 0, 0, 1, zsdc_pkg::DRV_STOP, P_IDLE, 0);
    plan_item(ACT_UPDATE, RUN_GO, 0, 65535, 1, zsdc_pkg::DRV_STOP, P_OUT_HOLD, 0);
    plan_item(ACT_UPDATE, RUN_GO, 4095, 65535, 1, zsdc_pkg::DRV_RIGHT, P_OUT_HOLD, 0);
    plan_item(ACT_UPDATE, RUN_GO, -4096, 65535, 1, zsdc_pkg::DRV_LEFT, P_OUT_HOLD, 0);
    plan_item(ACT_UPDATE, RUN_GO, 160, 65535);
    plan_item(ACT_UPDATE, RUN_GO, 0, 319);
    plan_item(ACT_UPDATE, RUN_GO, -1000, 0);
    plan_item(ACT_UPDATE, RUN_GO, -1281, 0);
    plan_cfg(zsdc_pkg::CFG_DWELL_TICKS, 16'd2);
    plan_item(ACT_UPDATE, RUN_GO, -1361, 0);
    plan_item(ACT_UPDATE, RUN_STOP, 0, 0);
    plan_item(ACT_TICK, RUN_GO, 0, 0);
    plan_item(ACT_TICK, RUN_GO, 0, 0);
    plan_item(ACT_UPDATE, RUN_GO, -2721, 0);
    plan_item(ACT_UPDATE, RUN_GO, 0, 65535);
    plan_item(ACT_UPDATE, RUN_STOP, 0, 65535, 1, zsdc_pkg::DRV_STOP, P_IDLE, 1);
    plan_item(ACT_UPDATE, RUN_GO, 0, 65535, 1, zsdc_pkg::DRV_STOP, P_RET_HOLD, 1);
    plan_item(ACT_UPDATE, RUN_GO, 2721, 65535);
    plan_item(ACT_UPDATE, RUN_GO, -2721, 159);
    plan_item(ACT_UPDATE, RUN_GO, -1439, 0);
    plan_cfg(zsdc_pkg::CFG_DWELL_TICKS, 16'd0);
    plan_item(ACT_UPDATE, RUN_GO, -1521, 0);
    plan_item(ACT_TICK, RUN_GO, 0, 0);
    plan_item(ACT_UPDATE, RUN_GO, -159, 0);
    plan_cfg(zsdc_pkg::CFG_HEADING_BAND, 16'hFFFF);
    plan_item(ACT_UPDATE, RUN_GO, 0, 65535);
    plan_item(ACT_UPDATE, RUN_GO, 4095, 0);
    plan_item(ACT_UPDATE, RUN_GO, 2000, 0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want);
        idle_gap(1'b0);
      end
    end

    set_band[0] = 16'd160;   set_near_out[0] = 16'd320;   set_near_ret[0] = 16'd160;
    set_dwell[0] = 16'd3;    set_items[0] = 450;
    set_band[1] = 16'd0;     set_near_out[1] = 16'hFFFF;  set_near_ret[1] = 16'hFFFF;
    set_dwell[1] = 16'd0;    set_items[1] = 350;
    set_band[2] = 16'hFFFF;  set_near_out[2] = 16'($urandom);
    set_near_ret[2] = 16'($urandom);
    set_dwell[2] = 16'd1;    set_items[2] = 300;
    set_band[3] = 16'($urandom_range(2880));
    set_near_out[3] = 16'($urandom_range(2000));
    set_near_ret[3] = 16'($urandom_range(2000));
    set_dwell[3] = 16'($urandom_range(12));
    set_items[3] = 400;
    set_band[4] = 16'd2880;  set_near_out[4] = 16'd0;     set_near_ret[4] = 16'd0;
    set_dwell[4] = 16'hFFFF; set_items[4] = 250;

    for (int k = 0; k < 5; k++) begin
      write_reg(zsdc_pkg::CFG_HEADING_BAND, set_band[k]);
      write_reg(zsdc_pkg::CFG_NEAR_OUT, set_near_out[k]);
      write_reg(zsdc_pkg::CFG_NEAR_RET, set_near_ret[k]);
      write_reg(zsdc_pkg::CFG_DWELL_TICKS, set_dwell[k]);
      for (int i = 0; i < set_items[k]; i++) begin
        if (k == 0 && i == 60) flood_req = 1'b1;
        send_request(shape_request(), 1'b0, '0);
        idle_gap((i / 64) % 4 == 1);
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("zigzag_sweep_drive_controller: match");
    end else begin
      $display("zigzag_sweep_drive_controller: mismatch");
    end
    $finish;
  end

endmodule
